@@ hw/rtl/ktp_pkg.sv @@
// ----------------------------------------------------------------------------
// ktp_pkg
// Shared types and constants of the Kosinski token packer.
// ----------------------------------------------------------------------------
package ktp_pkg;

	// descriptor geometry
	localparam int FLAG_BITS = 16;
	localparam int LEFT_W    = 5;

	// token codes on the input channel
	typedef enum logic [1:0] {
		OP_LIT   = 2'd0,
		OP_MATCH = 2'd1,
		OP_END   = 2'd2
	} opcode_t;

	// match encoding limits
	localparam logic [13:0] DIST_NEAR   = 14'h100;
	localparam logic [8:0]  LEN_MIN     = 9'd2;
	localparam logic [8:0]  LEN_SHORT   = 9'd5;
	localparam logic [8:0]  LEN_MID     = 9'd9;
	localparam logic [8:0]  LEN_MAX     = 9'h100;
	localparam logic [7:0]  TERM_MARK   = 8'hF0;

	// one decoded token: descriptor bits in shift order, then its data bytes
	typedef struct packed {
		logic            is_end;
		logic [2:0]      nbits;
		logic [3:0]      bits;
		logic [1:0]      nbytes;
		logic [2:0][7:0] data;
	} cmd_t;

endpackage

@@ hw/rtl/ktp_token_if.sv @@
// ----------------------------------------------------------------------------
// ktp_token_if
// Valid/ready channel carrying one LZSS token per beat.
// ----------------------------------------------------------------------------
interface ktp_token_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  literal_byte;
	logic [13:0] distance;
	logic [8:0]  length;

	modport source (output valid, opcode, literal_byte, distance, length, input ready);
	modport sink   (input valid, opcode, literal_byte, distance, length, output ready);
endinterface

@@ hw/rtl/ktp_byte_if.sv @@
// ----------------------------------------------------------------------------
// ktp_byte_if
// Valid/ready channel carrying one compressed byte per beat.
// ----------------------------------------------------------------------------
interface ktp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       stream_done;

	modport source (output valid, out_byte, run_last, stream_done, input ready);
	modport sink   (input valid, out_byte, run_last, stream_done, output ready);
endinterface

@@ hw/rtl/kosinski_token_packer_top.sv @@
// ----------------------------------------------------------------------------
// kosinski_token_packer_top
// Packs LZSS tokens into a Kosinski compressed byte stream.
// ----------------------------------------------------------------------------
// Tokens enter a classifier that drops opcode 3 and unencodable matches and
// writes the rest into a two-entry queue, so the input keeps taking tokens
// while the packer core is busy flushing, until the queue is full. The core
// handles one token at a time: it shifts in the descriptor bits, then writes
// each data byte into the group RAM (single write port). When the descriptor
// fills, the core streams 2 + N bytes (N held group bytes, at most 25)
// through the output register at one byte per cycle while the output is not
// stalled; the end mark always adds such a flush of its own. Apart from the
// end mark, no result comes out of a token that does not fill the descriptor.
// run_last marks the last byte of each token's output and stream_done the last
// byte of a stream; state then returns to its reset value.
// ----------------------------------------------------------------------------
module kosinski_token_packer_top import ktp_pkg::*; #(
	parameter int GROUP_DEPTH  = 32,
	parameter int MAX_DISTANCE = 8192
) (
	input  logic       clk,
	input  logic       arst_n,
	ktp_token_if.sink  token,
	ktp_byte_if.source stream
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// token classification
	ktp_front #(
		.MAX_DISTANCE (MAX_DISTANCE)
	) u_front (
		.token      (token),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decoupling queue
	ktp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// packer core
	ktp_back #(
		.GROUP_DEPTH (GROUP_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.stream    (stream)
	);

endmodule

@@ hw/rtl/ktp_ram.sv @@
// ----------------------------------------------------------------------------
// ktp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ktp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port; read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hw/rtl/ktp_front.sv @@
// ----------------------------------------------------------------------------
// ktp_front
// Token classifier: checks a token and turns it into descriptor bits and
// data bytes for the command queue.
// ----------------------------------------------------------------------------
module ktp_front import ktp_pkg::*; #(
	parameter int MAX_DISTANCE = 8192
) (
	ktp_token_if.sink  token,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_t       push_cmd
);

	logic [15:0] nd;
	logic [7:0]  l2;
	logic        keep;
	logic        match_ok;

	// negated distance and biased length
	assign nd = ~{2'b00, token.distance} + 16'd1;
	assign l2 = 8'(token.length - LEN_MIN);

	// match range checks
	assign match_ok = (token.distance != 14'd0)
		&& (token.distance <= 14'(MAX_DISTANCE))
		&& (token.length >= LEN_MIN) && (token.length <= LEN_MAX)
		&& !((token.length == LEN_MIN) && (token.distance > DIST_NEAR));

	// token decode
	always_comb begin
		keep     = 1'b0;
		push_cmd = '0;
		unique case (token.opcode)
			OP_LIT: begin
				keep             = 1'b1;
				push_cmd.nbits   = 3'd1;
				push_cmd.bits    = 4'b0001;
				push_cmd.nbytes  = 2'd1;
				push_cmd.data[0] = token.literal_byte;
			end
			OP_MATCH: begin
				keep             = match_ok;
				push_cmd.data[0] = nd[7:0];
				if ((token.length <= LEN_SHORT) && (token.distance <= DIST_NEAR)) begin
					push_cmd.nbits  = 3'd4;
					push_cmd.bits   = {l2[0], l2[1], 2'b00};
					push_cmd.nbytes = 2'd1;
				end else if (token.length <= LEN_MID) begin
					push_cmd.nbits   = 3'd2;
					push_cmd.bits    = 4'b0010;
					push_cmd.nbytes  = 2'd2;
					push_cmd.data[1] = {nd[12:8], l2[2:0]};
				end else begin
					push_cmd.nbits   = 3'd2;
					push_cmd.bits    = 4'b0010;
					push_cmd.nbytes  = 2'd3;
					push_cmd.data[1] = {nd[12:8], 3'b000};
					push_cmd.data[2] = 8'(token.length - 9'd1);
				end
			end
			OP_END: begin
				keep             = 1'b1;
				push_cmd.is_end  = 1'b1;
				push_cmd.nbits   = 3'd2;
				push_cmd.bits    = 4'b0010;
				push_cmd.nbytes  = 2'd3;
				push_cmd.data[1] = TERM_MARK;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// dropped tokens are taken without a queue entry
	assign token.ready = push_ready;
	assign push_valid  = token.valid && keep;

endmodule

@@ hw/rtl/ktp_fifo.sv @@
// ----------------------------------------------------------------------------
// ktp_fifo
// Two-entry command queue between the classifier and the packer core.
// ----------------------------------------------------------------------------
module ktp_fifo import ktp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ hw/rtl/ktp_back.sv @@
// ----------------------------------------------------------------------------
// ktp_back
// Packer core: shifts descriptor bits, holds group bytes in RAM and streams
// both out, one byte per cycle unless stalled, when the descriptor fills.
// ----------------------------------------------------------------------------
module ktp_back import ktp_pkg::*; #(
	parameter int GROUP_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  cmd_t       pop_cmd,
	ktp_byte_if.source stream
);

	localparam int CW = $clog2(GROUP_DEPTH + 1);
	localparam int AW = $clog2(GROUP_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DLO,
		ST_DHI,
		ST_GRP,
		ST_HOLD
	} state_t;

	state_t            state_q;
	logic [15:0]       shift_q;
	logic [LEFT_W-1:0] left_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [1:0]        hold_idx_q;
	logic              final_q;
	cmd_t              cmd_q;
	logic [15:0]       desc_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_done_q;

	logic              can_emit;
	logic              load_out;
	logic              fill;
	logic [15:0]       shift_new;
	logic [15:0]       desc_fill;
	logic [LEFT_W-1:0] left_new;
	logic [LEFT_W-1:0] nbits_ext;
	logic              grp_end;
	logic              hold_end;
	logic              flush_last;
	logic              ram_wr_en;
	logic              ram_rd_en;
	logic [AW-1:0]     ram_rd_addr;
	logic [7:0]        ram_rd_data;

	// output register frees when empty or taken
	assign can_emit = !out_valid_q || stream.ready;
	assign pop_ready = (state_q == ST_IDLE);

	// a new beat enters the output register in the flush states
	assign load_out = can_emit
		&& ((state_q == ST_DLO) || (state_q == ST_DHI) || (state_q == ST_GRP));

	// descriptor update for the command at the queue head
	always_comb begin
		shift_new = shift_q;
		desc_fill = shift_q;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < pop_cmd.nbits) begin
				shift_new = {pop_cmd.bits[i], shift_new[15:1]};
				if (LEFT_W'(i + 1) == left_q) begin
					desc_fill = shift_new;
				end
			end
		end
	end

	assign nbits_ext = {2'b00, pop_cmd.nbits};
	assign fill      = (nbits_ext >= left_q);
	assign left_new  = fill ? (LEFT_W'(FLAG_BITS) - (nbits_ext - left_q)) : (left_q - nbits_ext);

	// flush sequencing
	assign grp_end    = (idx_q == count_q);
	assign hold_end   = (hold_idx_q == (cmd_q.nbytes - 2'd1));
	assign flush_last = !cmd_q.is_end || final_q;

	// group RAM control
	assign ram_wr_en   = (state_q == ST_HOLD) && (count_q < CW'(GROUP_DEPTH));
	assign ram_rd_en   = can_emit && (((state_q == ST_DHI) && (count_q != '0))
		|| ((state_q == ST_GRP) && !grp_end));
	assign ram_rd_addr = (state_q == ST_DHI) ? '0 : idx_q[AW-1:0];

	ktp_ram #(
		.WIDTH (8),
		.DEPTH (GROUP_DEPTH)
	) u_group_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (cmd_q.data[hold_idx_q]),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			shift_q     <= '0;
			left_q      <= LEFT_W'(FLAG_BITS);
			count_q     <= '0;
			idx_q       <= '0;
			hold_idx_q  <= '0;
			final_q     <= 1'b0;
			cmd_q       <= '0;
			desc_q      <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_done_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (stream.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						cmd_q      <= pop_cmd;
						shift_q    <= shift_new;
						left_q     <= left_new;
						hold_idx_q <= '0;
						final_q    <= 1'b0;
						desc_q     <= desc_fill;
						state_q    <= fill ? ST_DLO : ST_HOLD;
					end
				end
				ST_DLO: begin
					if (can_emit) begin
						out_byte_q  <= desc_q[7:0];
						out_last_q  <= 1'b0;
						out_done_q  <= 1'b0;
						state_q     <= ST_DHI;
					end
				end
				ST_DHI: begin
					if (can_emit) begin
						out_byte_q  <= desc_q[15:8];
						out_last_q  <= (count_q == '0) && flush_last;
						out_done_q  <= (count_q == '0) && final_q;
						idx_q       <= CW'(1);
						if (count_q != '0) begin
							state_q <= ST_GRP;
						end else begin
							count_q <= '0;
							if (final_q) begin
								shift_q <= '0;
								left_q  <= LEFT_W'(FLAG_BITS);
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_HOLD;
							end
						end
					end
				end
				ST_GRP: begin
					if (can_emit) begin
						out_byte_q  <= ram_rd_data;
						out_last_q  <= grp_end && flush_last;
						out_done_q  <= grp_end && final_q;
						if (!grp_end) begin
							idx_q <= idx_q + CW'(1);
						end else begin
							count_q <= '0;
							if (final_q) begin
								shift_q <= '0;
								left_q  <= LEFT_W'(FLAG_BITS);
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_HOLD;
							end
						end
					end
				end
				ST_HOLD: begin
					if (count_q < CW'(GROUP_DEPTH)) begin
						count_q <= count_q + CW'(1);
					end
					hold_idx_q <= hold_idx_q + 2'd1;
					if (hold_end) begin
						if (cmd_q.is_end) begin
							desc_q  <= shift_q >> left_q;
							final_q <= 1'b1;
							state_q <= ST_DLO;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stream.valid       = out_valid_q;
	assign stream.out_byte    = out_byte_q;
	assign stream.run_last    = out_last_q;
	assign stream.stream_done = out_done_q;

endmodule

@@ hw/rtl/ktp_checker.sv @@
// ----------------------------------------------------------------------------
// ktp_checker
// Port-level checks of the token packer, bound to the top level.
// ----------------------------------------------------------------------------
module ktp_checker import ktp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_opcode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       out_done
);

	logic [2:0] end_pend_q;
	logic       end_in;
	logic       done_out;

	assign end_in   = in_valid && in_ready && (in_opcode == OP_END);
	assign done_out = out_valid && out_ready && out_done;

	// end marks taken but not yet closed by a stream_done beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_pend_q <= '0;
		end else if (end_in && !done_out) begin
			end_pend_q <= end_pend_q + 3'd1;
		end else if (done_out && !end_in && (end_pend_q != '0)) begin
			end_pend_q <= end_pend_q - 3'd1;
		end
	end

	// stalled beat keeps its valid
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// stalled beat keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last) && $stable(out_done))
		else $error("output payload changed while stalled");

	// the stream end is also the end of the end mark's bytes
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_done |-> out_last)
		else $error("stream_done without run_last");

	// a stream only ends after an end mark was taken
	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		done_out |-> (end_pend_q != '0) || end_in)
		else $error("stream_done with no end mark outstanding");

endmodule

bind kosinski_token_packer_top ktp_checker u_ktp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (token.valid),
	.in_ready  (token.ready),
	.in_opcode (token.opcode),
	.out_valid (stream.valid),
	.out_ready (stream.ready),
	.out_byte  (stream.out_byte),
	.out_last  (stream.run_last),
	.out_done  (stream.stream_done)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Token stream check of the Kosinski token packer: directed corner tokens and
// random streams are sent over the token channel while a local packing model
// tracks the descriptor and held group bytes and queues every byte expected on
// the output channel; each output beat is compared against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
	import ktp_pkg::*;

	localparam int GROUP_DEPTH      = 32;
	localparam int MAX_DISTANCE     = 8192;
	localparam int MAX_TOKEN_BYTES  = 32;
	localparam int MAIN_TOKENS      = 75;
	localparam int REPORT_LIMIT     = 100;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_done;
	} stream_beat_t;

	logic clk;
	logic arst_n;

	ktp_token_if token_ch ();
	ktp_byte_if  stream_ch ();

	kosinski_token_packer_top #(
		.GROUP_DEPTH  (GROUP_DEPTH),
		.MAX_DISTANCE (MAX_DISTANCE)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.token  (token_ch),
		.stream (stream_ch)
	);

	// packing model state
	logic [15:0]  desc_shift;
	int unsigned  desc_free;
	logic [7:0]   group_held[$];
	stream_beat_t token_bytes[$];
	stream_beat_t expected_bytes[$];

	int unsigned  packed_tokens;
	int unsigned  error_count;
	int unsigned  sink_hold_off;
	bit           steady_source;
	bit           steady_sink;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("kosinski_token_packer_top test failed");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return $urandom_range(0, 2);
		end else if (r < 92) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_packer_state();
		desc_shift = '0;
		desc_free  = FLAG_BITS;
		group_held.delete();
	endfunction

	function automatic void emit_stream_byte(input logic [7:0] value);
		stream_beat_t beat;
		if (token_bytes.size() < MAX_TOKEN_BYTES) begin
			beat.out_byte    = value;
			beat.run_last    = 1'b0;
			beat.stream_done = 1'b0;
			token_bytes.push_back(beat);
		end
	endfunction

	function automatic void hold_group_byte(input logic [7:0] value);
		if (group_held.size() < GROUP_DEPTH) begin
			group_held.push_back(value);
		end
	endfunction

	// descriptor low byte first, then the held bytes of the group
	function automatic void flush_group(input logic [15:0] desc);
		emit_stream_byte(desc[7:0]);
		emit_stream_byte(desc[15:8]);
		foreach (group_held[i]) begin
			emit_stream_byte(group_held[i]);
		end
		group_held.delete();
	endfunction

	// new bit enters at the top, a full descriptor flushes its group
	function automatic void shift_flag_bit(input logic flag);
		desc_shift = {flag, desc_shift[15:1]};
		if (desc_free > 0) begin
			desc_free--;
		end
		if (desc_free == 0) begin
			desc_free = FLAG_BITS;
			flush_group(desc_shift);
		end
	endfunction

	// expected output bytes of one accepted token
	function automatic void pack_token(input logic [1:0] op, input logic [7:0] lit,
			input logic [13:0] match_dist, input logic [8:0] len);
		logic [15:0] neg_dist;
		logic [8:0]  len_m2;
		logic [8:0]  len_m1;
		int unsigned align;
		stream_beat_t last_beat;
		token_bytes.delete();
		neg_dist = 16'h0000 - {2'b00, match_dist};
		len_m2   = len - LEN_MIN;
		len_m1   = len - 9'd1;
		case (op)
			OP_LIT: begin
				shift_flag_bit(1'b1);
				hold_group_byte(lit);
			end
			OP_MATCH: begin
				// unencodable matches leave no trace
				if (match_dist == 0 || match_dist > MAX_DISTANCE || len < LEN_MIN ||
						len > LEN_MAX || (len == LEN_MIN && match_dist > DIST_NEAR)) begin
					return;
				end
				if (len <= LEN_SHORT && match_dist <= DIST_NEAR) begin
					shift_flag_bit(1'b0);
					shift_flag_bit(1'b0);
					shift_flag_bit(len_m2[1]);
					shift_flag_bit(len_m2[0]);
					hold_group_byte(neg_dist[7:0]);
				end else if (len <= LEN_MID) begin
					shift_flag_bit(1'b0);
					shift_flag_bit(1'b1);
					hold_group_byte(neg_dist[7:0]);
					hold_group_byte({neg_dist[12:8], len_m2[2:0]});
				end else begin
					shift_flag_bit(1'b0);
					shift_flag_bit(1'b1);
					hold_group_byte(neg_dist[7:0]);
					hold_group_byte({neg_dist[12:8], 3'b000});
					hold_group_byte(len_m1[7:0]);
				end
			end
			OP_END: begin
				// terminator, then the right-aligned partial descriptor
				shift_flag_bit(1'b0);
				shift_flag_bit(1'b1);
				hold_group_byte(8'h00);
				hold_group_byte(TERM_MARK);
				hold_group_byte(8'h00);
				align = desc_free;
				flush_group(desc_shift >> align);
				last_beat = token_bytes[token_bytes.size() - 1];
				last_beat.stream_done = 1'b1;
				token_bytes[token_bytes.size() - 1] = last_beat;
				clear_packer_state();
			end
			default: begin
				return;
			end
		endcase
		packed_tokens++;
		if (token_bytes.size() > 0) begin
			last_beat = token_bytes[token_bytes.size() - 1];
			last_beat.run_last = 1'b1;
			token_bytes[token_bytes.size() - 1] = last_beat;
		end
		foreach (token_bytes[i]) begin
			expected_bytes.push_back(token_bytes[i]);
		end
	endfunction

	// one token beat; valid stays high afterwards for a back-to-back follower
	task automatic send_token(input logic [1:0] op, input logic [7:0] lit,
			input logic [13:0] match_dist, input logic [8:0] len);
		int unsigned gap;
		gap = steady_source ? 0 : pick_gap();
		if (gap != 0) begin
			token_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		token_ch.valid        <= 1'b1;
		token_ch.opcode       <= op;
		token_ch.literal_byte <= lit;
		token_ch.distance     <= match_dist;
		token_ch.length       <= len;
		do @(posedge clk); while (token_ch.ready !== 1'b1);
		pack_token(op, lit, match_dist, len);
	endtask

	// random well-formed tokens, with some noise mixed in when asked
	task automatic send_stream_tokens(input int unsigned count, input bit noisy);
		int unsigned r;
		int unsigned len;
		int unsigned match_dist;
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (noisy && r < 4) begin
				send_token(OP_UNUSED, 8'($urandom), 14'($urandom), 9'($urandom));
			end else if (noisy && r < 8) begin
				// broken match
				case ($urandom_range(0, 4))
					0: send_token(OP_MATCH, 8'($urandom), 14'd0, 9'($urandom_range(0, 511)));
					1: send_token(OP_MATCH, 8'($urandom),
						14'($urandom_range(MAX_DISTANCE + 1, 16383)),
						9'($urandom_range(2, 256)));
					2: send_token(OP_MATCH, 8'($urandom), 14'($urandom_range(1, 16383)),
						9'($urandom_range(0, 1)));
					3: send_token(OP_MATCH, 8'($urandom), 14'($urandom_range(1, 16383)),
						9'($urandom_range(257, 511)));
					default: send_token(OP_MATCH, 8'($urandom),
						14'($urandom_range(DIST_NEAR + 1, MAX_DISTANCE)), LEN_MIN);
				endcase
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					send_token(OP_LIT, 8'($urandom), 14'($urandom), 9'($urandom));
				end else begin
					if (r < 60) begin
						len        = $urandom_range(2, 5);
						match_dist = $urandom_range(1, DIST_NEAR);
					end else if (r < 78) begin
						len        = $urandom_range(3, 9);
						match_dist = (len <= LEN_SHORT)
							? $urandom_range(DIST_NEAR + 1, MAX_DISTANCE)
							: $urandom_range(1, MAX_DISTANCE);
					end else begin
						len        = ($urandom_range(0, 7) == 0) ? LEN_MAX
							: $urandom_range(10, 256);
						match_dist = $urandom_range(1, MAX_DISTANCE);
					end
					// pull the distance to its edges now and then
					if ($urandom_range(0, 9) == 0) begin
						match_dist = (len <= LEN_SHORT && match_dist <= DIST_NEAR)
							? DIST_NEAR : MAX_DISTANCE;
					end else if ($urandom_range(0, 9) == 0 && len > LEN_MIN) begin
						match_dist = 1;
					end
					send_token(OP_MATCH, 8'($urandom), 14'(match_dist), 9'(len));
				end
			end
		end
	endtask

	task automatic wait_stream_drained();
		token_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	// field extremes, every match class and the ignored forms
	task automatic test_directed_tokens();
		send_token(OP_END, 8'h00, 14'd0, 9'd0);
		send_token(OP_LIT, 8'h00, 14'd0, 9'd0);
		send_token(OP_LIT, 8'hFF, 14'h3FFF, 9'h1FF);
		send_token(OP_MATCH, 8'h00, 14'd1, 9'd2);
		send_token(OP_MATCH, 8'h00, DIST_NEAR, 9'd5);
		send_token(OP_MATCH, 8'h00, DIST_NEAR + 14'd1, 9'd2);
		send_token(OP_MATCH, 8'h00, DIST_NEAR + 14'd1, 9'd3);
		send_token(OP_MATCH, 8'h00, 14'(MAX_DISTANCE), 9'd9);
		// last bit of this one fills the descriptor
		send_token(OP_MATCH, 8'h00, 14'd1, 9'd10);
		send_token(OP_MATCH, 8'h00, 14'(MAX_DISTANCE), LEN_MAX);
		send_token(OP_MATCH, 8'h00, 14'd0, 9'd4);
		send_token(OP_MATCH, 8'h00, 14'(MAX_DISTANCE + 1), 9'd4);
		send_token(OP_MATCH, 8'h00, 14'd5, 9'd1);
		send_token(OP_MATCH, 8'h00, 14'd5, LEN_MAX + 9'd1);
		send_token(OP_MATCH, 8'hFF, 14'h3FFF, 9'h1FF);
		send_token(OP_UNUSED, 8'hFF, 14'h3FFF, 9'h1FF);
		send_token(OP_MATCH, 8'h00, 14'h80, 9'd3);
		send_token(OP_MATCH, 8'h00, 14'hFF, 9'd4);
		send_token(OP_MATCH, 8'h00, 14'd2, 9'd5);
		// fills after two of its four bits, its byte goes to the next group
		send_token(OP_MATCH, 8'h00, DIST_NEAR, 9'd2);
		send_token(OP_MATCH, 8'h00, 14'd3, 9'd3);
		send_token(OP_MATCH, 8'h00, 14'd4, 9'd4);
		send_token(OP_MATCH, 8'h00, 14'd5, 9'd5);
		// end mark fills the descriptor, then flushes its own terminator
		send_token(OP_END, 8'h00, 14'd0, 9'd0);
	endtask

	task automatic test_random_streams();
		int unsigned target;
		target = packed_tokens + MAIN_TOKENS;
		while (packed_tokens < target) begin
			steady_source = ($urandom_range(0, 5) == 0);
			steady_sink   = ($urandom_range(0, 5) == 0);
			send_stream_tokens(($urandom_range(0, 4) != 0) ? $urandom_range(0, 12)
				: $urandom_range(13, 50), 1'b1);
			// a few streams run on into the next without an end mark
			if ($urandom_range(0, 9) != 0) begin
				send_token(OP_END, 8'($urandom), 14'($urandom), 9'($urandom));
			end
		end
		steady_source = 1'b0;
		steady_sink   = 1'b0;
	endtask

	// output held off while tokens keep coming, so the input backs up
	task automatic test_sink_hold_off();
		steady_source = 1'b1;
		sink_hold_off = 300;
		send_stream_tokens(40, 1'b0);
		send_token(OP_END, 8'h00, 14'd0, 9'd0);
		steady_source = 1'b0;
	endtask

	// stop mid-stream until every byte so far has come out, then go on
	task automatic test_source_pause();
		send_stream_tokens(9, 1'b0);
		wait_stream_drained();
		send_stream_tokens(9, 1'b0);
		send_token(OP_END, 8'h00, 14'd0, 9'd0);
	endtask

	// output ready pattern
	initial begin
		int unsigned n;
		stream_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold_off != 0) begin
				n = sink_hold_off;
				sink_hold_off = 0;
				stream_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (steady_sink) begin
				stream_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				stream_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				n = pick_gap();
				if (n != 0) begin
					stream_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// compare each output beat with the oldest expected byte
	always @(posedge clk) begin
		stream_beat_t got;
		stream_beat_t want;
		if (arst_n === 1'b1 && stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1) begin
			got.out_byte    = stream_ch.out_byte;
			got.run_last    = stream_ch.run_last;
			got.stream_done = stream_ch.stream_done;
			if (expected_bytes.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT) begin
					$display("%0t: unexpected beat, expected none, actual %02h/%0b/%0b",
						$time, got.out_byte, got.run_last, got.stream_done);
				end
			end else begin
				want = expected_bytes.pop_front();
				if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
						got.stream_done !== want.stream_done) begin
					error_count++;
					if (error_count <= REPORT_LIMIT) begin
						$display("%0t: beat mismatch, expected %02h/%0b/%0b, actual %02h/%0b/%0b",
							$time, want.out_byte, want.run_last, want.stream_done,
							got.out_byte, got.run_last, got.stream_done);
					end
				end
			end
		end
	end

	// reset and test sequence
	initial begin
		arst_n                <= 1'b0;
		token_ch.valid        <= 1'b0;
		token_ch.opcode       <= OP_LIT;
		token_ch.literal_byte <= '0;
		token_ch.distance     <= '0;
		token_ch.length       <= '0;
		packed_tokens = 0;
		error_count   = 0;
		sink_hold_off = 0;
		steady_source = 1'b0;
		steady_sink   = 1'b0;
		clear_packer_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_tokens();
		test_random_streams();
		test_sink_hold_off();
		test_source_pause();

		// drain, then watch a while for stray beats
		wait_stream_drained();
		steady_sink = 1'b1;
		repeat (64) @(posedge clk);
		if (error_count == 0 && expected_bytes.size() == 0) begin
			$display("kosinski_token_packer_top test passed");
		end else begin
			$display("kosinski_token_packer_top test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ktp_pkg.sv
hw/rtl/ktp_token_if.sv
hw/rtl/ktp_byte_if.sv
hw/rtl/ktp_ram.sv
hw/rtl/ktp_front.sv
hw/rtl/ktp_fifo.sv
hw/rtl/ktp_back.sv
hw/rtl/kosinski_token_packer_top.sv
hw/rtl/ktp_checker.sv
tb/testbench.sv
